>>> sv/access_log_field_tokenizer_macros.svh
// Assertion macros shared by the access-log field tokenizer RTL.
`ifndef ACCESS_LOG_FIELD_TOKENIZER_MACROS_SVH
`define ACCESS_LOG_FIELD_TOKENIZER_MACROS_SVH

// Same-cycle implication, checked at every rising clock edge outside reset.
`define ALFT_ASSERT_IMPL(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked at every rising clock edge outside reset.
`define ALFT_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> sv/alft_pkg.sv
// Types, constants and helper functions of the access-log field tokenizer.
package alft_pkg;

  // Width of the field mode register and its value after reset.
  localparam int unsigned TableW = 20;
  localparam logic [TableW-1:0] MODE_TABLE_RESET = 20'd164416;

  // Most result words that one input word can cause.
  localparam int unsigned MaxResults = 4;

  // Bytes with a meaning of their own.
  localparam logic [7:0] CHAR_LBRACKET = 8'h5B;
  localparam logic [7:0] CHAR_RBRACKET = 8'h5D;
  localparam logic [7:0] CHAR_QUOTE    = 8'h22;

  // Field mode codes; the unused code behaves as word mode.
  localparam logic [1:0] MODE_WORD    = 2'd0;
  localparam logic [1:0] MODE_BRACKET = 2'd1;
  localparam logic [1:0] MODE_QUOTE   = 2'd2;

  typedef enum logic [2:0] {
    PH_BETWEEN = 3'd0,
    PH_WORD    = 3'd1,
    PH_BRACKET = 3'd2,
    PH_QLEAD   = 3'd3,
    PH_QUOTE   = 3'd4,
    PH_DONE    = 3'd5
  } phase_e;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_line;
  } in_word_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic [3:0] field_number;
    logic       field_end;
    logic       line_done;
    logic       line_valid;
    logic       last;
  } out_word_t;

  // Per-line parser state, including the held quote lookahead bytes.
  typedef struct packed {
    phase_e          phase;
    logic [3:0]      cur_field;
    logic [2:0][7:0] window;
    logic [1:0]      win_cnt;
    logic [3:0]      fields_started;
  } line_state_t;

  // Result words of one input word, filled from index zero.
  typedef struct packed {
    out_word_t [MaxResults-1:0] word;
    logic [2:0]                 count;
  } res_list_t;

  function automatic logic is_space(logic [7:0] c);
    return c inside {8'h20, [8'h09:8'h0D]};
  endfunction

  // A byte that marks the quote two places before it as a closing quote.
  function automatic logic is_term(logic [7:0] c);
    return c inside {[8'h30:8'h39], CHAR_QUOTE};
  endfunction

  function automatic out_word_t make_word(logic [7:0] b, logic bv, logic fe,
                                          logic [3:0] fnum);
    out_word_t w;
    w = '0;
    w.out_byte     = bv ? b : 8'h00;
    w.byte_valid   = bv;
    w.field_number = fnum;
    w.field_end    = fe;
    return w;
  endfunction

  // Append a word; words beyond the list capacity are dropped.
  function automatic res_list_t push(res_list_t l, out_word_t w);
    res_list_t r;
    r = l;
    if (l.count < 3'(MaxResults)) begin
      r.word[l.count[1:0]] = w;
      r.count = l.count + 3'd1;
    end
    return r;
  endfunction

endpackage

>>> sv/alft_step.sv
// Single-pass tokenizer step: one input word against the line state.
module alft_step #(
  parameter int NUM_FIELDS = 10
) (
  input  logic [alft_pkg::TableW-1:0] cfg_table_i,
  input  alft_pkg::line_state_t       state_i,
  input  alft_pkg::in_word_t          word_i,
  output alft_pkg::line_state_t       state_o,
  output alft_pkg::res_list_t         res_o
);
  import alft_pkg::*;

  localparam logic [3:0] NumF = 4'(NUM_FIELDS);

  always_comb begin
    logic [3:0][7:0] buf_w;
    logic [2:0]      n;
    logic [2:0]      pos;
    logic [2:0]      keep;
    logic            hold;
    logic            done;
    logic            eol;
    logic            closing;
    logic            dropped;
    logic            lk_wait;
    logic [7:0]      c;
    logic [1:0]      mode;
    phase_e          ph;
    logic [3:0]      cf;
    logic [3:0]      fs;
    logic [2:0][7:0] win;
    res_list_t       res;
    logic [1:0]      tail;

    // Held bytes first, then the new byte.
    buf_w = {8'h00, state_i.window};
    buf_w[state_i.win_cnt] = word_i.in_byte;
    n     = {1'b0, state_i.win_cnt} + 3'd1;
    eol   = word_i.end_of_line;
    ph    = state_i.phase;
    cf    = state_i.cur_field;
    fs    = state_i.fields_started;
    res   = '0;
    pos   = '0;
    hold  = 1'b0;
    c     = '0;
    mode  = '0;
    done  = 1'b0;
    closing = 1'b0;
    dropped = 1'b0;
    lk_wait = 1'b0;

    // Walk the window bytes in order until one must wait for lookahead.
    for (int p = 0; p < 4; p++) begin
      if (!hold && (3'(p) < n)) begin
        c    = buf_w[p];
        done = 1'b0;

        // Start of a field: pick the mode of the next field.
        if (ph == PH_BETWEEN) begin
          if (is_space(c)) begin
            done = 1'b1;
          end else if (cf >= NumF) begin
            ph   = PH_DONE;
            done = 1'b1;
          end else begin
            fs   = fs + 4'd1;
            mode = 2'(cfg_table_i >> {cf, 1'b0});
            if (mode == MODE_BRACKET) begin
              ph   = PH_BRACKET;
              done = (c == CHAR_LBRACKET);
            end else if (mode == MODE_QUOTE) begin
              ph = PH_QLEAD;
            end else begin
              ph = PH_WORD;
            end
          end
        end

        // Leading quotes of a quote field are skipped.
        if (!done && ph == PH_QLEAD) begin
          if (c == CHAR_QUOTE) begin
            done = 1'b1;
          end else begin
            ph = PH_QUOTE;
          end
        end

        if (!done) begin
          case (ph)
            PH_WORD: begin
              if (is_space(c)) begin
                res = push(res, make_word(8'h00, 1'b0, 1'b1, cf));
                cf  = cf + 4'd1;
                ph  = (cf >= NumF) ? PH_DONE : PH_BETWEEN;
              end else begin
                res = push(res, make_word(c, 1'b1, 1'b0, cf));
              end
            end
            PH_BRACKET: begin
              if (c == CHAR_RBRACKET) begin
                res = push(res, make_word(8'h00, 1'b0, 1'b1, cf));
                cf  = cf + 4'd1;
                ph  = (cf >= NumF) ? PH_DONE : PH_BETWEEN;
              end else begin
                res = push(res, make_word(c, 1'b1, 1'b0, cf));
              end
            end
            PH_QUOTE: begin
              if (c != CHAR_QUOTE) begin
                res = push(res, make_word(c, 1'b1, 1'b0, cf));
              end else begin
                // A quote closes the field when the byte two later is a digit
                // or a quote; past the end of the line it never does.
                lk_wait = 1'b0;
                closing = 1'b0;
                dropped = 1'b0;
                if (3'(p + 2) < n) begin
                  closing = is_term(buf_w[2'(p + 2)]);
                end else if (!eol) begin
                  lk_wait = 1'b1;
                end
                if (!lk_wait && closing) begin
                  res = push(res, make_word(8'h00, 1'b0, 1'b1, cf));
                  cf  = cf + 4'd1;
                  ph  = (cf >= NumF) ? PH_DONE : PH_BETWEEN;
                end else if (!lk_wait) begin
                  // A quote doubled in front of the closing quote is dropped.
                  if (3'(p + 1) < n && buf_w[2'(p + 1)] == CHAR_QUOTE) begin
                    if (3'(p + 3) < n) begin
                      dropped = is_term(buf_w[2'(p + 3)]);
                    end else if (!eol) begin
                      lk_wait = 1'b1;
                    end
                  end
                  if (!lk_wait && !dropped) begin
                    res = push(res, make_word(CHAR_QUOTE, 1'b1, 1'b0, cf));
                  end
                end
                hold = lk_wait;
              end
            end
            default: begin
            end
          endcase
        end

        if (!hold) begin
          pos = pos + 3'd1;
        end
      end
    end

    // Undecided bytes stay in the window.
    keep = n - pos;
    if (keep > 3'd3) begin
      keep = 3'd3;
    end
    win = '0;
    for (int i = 0; i < 3; i++) begin
      if (3'(i) < keep) begin
        win[i] = buf_w[2'(pos + 3'(i))];
      end
    end

    // End of line: close an open field and report the line.
    if (eol) begin
      if (ph inside {PH_WORD, PH_BRACKET, PH_QLEAD, PH_QUOTE}) begin
        tail = 2'(res.count - 3'd1);
        if (res.count != 3'd0 && res.word[tail].byte_valid &&
            !res.word[tail].field_end && res.word[tail].field_number == cf) begin
          res.word[tail].field_end = 1'b1;
        end else begin
          res = push(res, make_word(8'h00, 1'b0, 1'b1, cf));
        end
        cf = cf + 4'd1;
        ph = (cf >= NumF) ? PH_DONE : PH_BETWEEN;
      end
      if (res.count == 3'd0) begin
        res = push(res, make_word(8'h00, 1'b0, 1'b0, 4'd0));
      end
      tail = 2'(res.count - 3'd1);
      res.word[tail].line_done  = 1'b1;
      res.word[tail].line_valid = (fs >= NumF);
      ph   = PH_BETWEEN;
      cf   = '0;
      fs   = '0;
      keep = '0;
      win  = '0;
    end

    if (res.count != 3'd0) begin
      tail = 2'(res.count - 3'd1);
      res.word[tail].last = 1'b1;
    end

    state_o.phase          = ph;
    state_o.cur_field      = cf;
    state_o.window         = win;
    state_o.win_cnt        = keep[1:0];
    state_o.fields_started = fs;
    res_o                  = res;
  end

endmodule

>>> sv/access_log_field_tokenizer.sv
// Top level of the access-log field tokenizer: input register, step logic, result buffer.
//
//   port group  | direction | handshake          | word
//   in_*        | in        | in_valid_i/in_stall_o  | in_word_t (byte, end of line)
//   out_*       | out       | out_valid_o/out_stall_i | out_word_t (field byte and marks)
//   cfg_*       | in        | cfg_we_i           | 20-bit field mode table
//
// An input word is held in the input register and passes through the combinational step
// logic into the result buffer; a word that causes k results holds the next input while
// the single output port drains the buffer one word per cycle when the output does not stall.
// A word that causes no result, or one, lets a new word enter every cycle while the output does not stall.
// Reset clears the line state, empties both registers and loads the default mode table.
// A stalled output keeps its word; the input stalls while the buffer cannot take more.
`include "access_log_field_tokenizer_macros.svh"

module access_log_field_tokenizer #(
  parameter int NUM_FIELDS = 10
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  alft_pkg::in_word_t          in_word_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output alft_pkg::out_word_t         out_word_o,
  input  logic                        cfg_we_i,
  input  logic [alft_pkg::TableW-1:0] cfg_wdata_i
);
  import alft_pkg::*;

  logic [TableW-1:0]           table_q;
  in_word_t                    in_q;
  logic                        in_valid_q;
  line_state_t                 state_q;
  line_state_t                 state_d;
  res_list_t                   res_d;
  out_word_t [MaxResults-1:0]  res_q;
  logic [2:0]                  res_cnt_q;
  logic [1:0]                  res_rd_q;
  logic                        out_take;
  logic                        fire;
  logic                        in_take;

  // Handshakes: the step fires once the buffer empties in this cycle.
  assign out_valid_o = (res_cnt_q != 3'd0);
  assign out_word_o  = res_q[res_rd_q];
  assign out_take    = out_valid_o && !out_stall_i;
  assign fire        = in_valid_q &&
                       ((res_cnt_q == 3'd0) || (res_cnt_q == 3'd1 && out_take));
  assign in_stall_o  = in_valid_q && !fire;
  assign in_take     = in_valid_i && !in_stall_o;

  alft_step #(
    .NUM_FIELDS (NUM_FIELDS)
  ) u_step (
    .cfg_table_i (table_q),
    .state_i     (state_q),
    .word_i      (in_q),
    .state_o     (state_d),
    .res_o       (res_d)
  );

  // Mode table register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      table_q <= MODE_TABLE_RESET;
    end else if (cfg_we_i) begin
      table_q <= cfg_wdata_i;
    end
  end

  // Input register payload.
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_q <= in_word_i;
    end
  end

  // Input register valid and line state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
      state_q    <= '{phase: PH_BETWEEN, default: '0};
    end else begin
      if (in_take) begin
        in_valid_q <= 1'b1;
      end else if (fire) begin
        in_valid_q <= 1'b0;
      end
      if (fire) begin
        state_q <= state_d;
      end
    end
  end

  // Result buffer payload.
  always_ff @(posedge clk_i) begin
    if (fire) begin
      res_q <= res_d.word;
    end
  end

  // Result buffer count and read pointer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_cnt_q <= '0;
      res_rd_q  <= '0;
    end else if (fire) begin
      res_cnt_q <= res_d.count;
      res_rd_q  <= '0;
    end else if (out_take) begin
      res_cnt_q <= res_cnt_q - 3'd1;
      res_rd_q  <= res_rd_q + 2'd1;
    end
  end

  // Held lookahead bytes only ever start with a quote inside a quote field.
  `ALFT_ASSERT_IMPL(a_win_quote, clk_i, rst_ni, state_q.win_cnt != 2'd0, state_q.phase == PH_QUOTE && state_q.window[0] == CHAR_QUOTE, "lookahead held outside a quote field")
  // The word marked last is the final word in the buffer.
  `ALFT_ASSERT_IMPL(a_last_tail, clk_i, rst_ni, out_valid_o && out_word_o.last, res_cnt_q == 3'd1, "last mark not on the final buffered word")
  // The field counter never runs past the field count.
  `ALFT_ASSERT_IMPL(a_field_range, clk_i, rst_ni, 1'b1, state_q.cur_field <= 4'(NUM_FIELDS), "field counter out of range")
  // A new result list is read from its first entry.
  `ALFT_ASSERT_NEXT(a_fire_load, clk_i, rst_ni, fire, res_rd_q == 2'd0, "read pointer not reset on load")

endmodule
